/* hw/rtl/lbrp_pkg.sv */
// Package for the log-bucket relative position index block.
// Holds field widths, parameter defaults and the elaboration-time functions
// that fill the log bucket ROM. No dependencies.
package lbrp_pkg;

  localparam int POS_W        = 9;
  localparam int OUT_W        = 19;
  localparam int MAX_DIST     = (2 ** POS_W) - 1;
  localparam int BUCKETS_DEF  = 256;
  localparam int MAX_REL_DEF  = 512;

  // Base-2 logarithm in fixed point: integer part from bit 32 up, 32 fraction
  // bits, truncated. Evaluated at elaboration only.
  function automatic longint log2_fix(input int unsigned v);
    int unsigned t;
    int          e;
    logic [127:0] m;
    logic [63:0]  frac;
    t    = v;
    e    = 0;
    frac = '0;
    if (v == 0) begin
      return 0;
    end
    while (t > 1) begin
      t = t >> 1;
      e = e + 1;
    end
    m = 128'(v) << (31 - e);
    for (int i = 0; i < 32; i++) begin
      m    = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (128'd1 << 32)) begin
        frac = frac | 64'd1;
        m    = m >> 1;
      end
    end
    return longint'((64'(e) << 32) | frac);
  endfunction

  // Unsigned restoring division, used at elaboration when filling the ROM.
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Signed bucket magnitude for a distance magnitude a above half the bucket
  // count, saturated to +/- buckets since the clamp makes larger values equal.
  function automatic int bucket_mag(input int a, input int buckets, input int max_rel);
    int     mid;
    int     r;
    longint lmid;
    longint num;
    longint den;
    longint p;
    longint n;
    longint mag;
    mid  = buckets >>> 1;
    r    = (max_rel > 1) ? (max_rel - 1) : 1;
    lmid = log2_fix(int'(mid));
    num  = log2_fix(a) - lmid;
    den  = log2_fix(r) - lmid;
    p    = longint'(mid - 1) * num;
    if (den > 0) begin
      n = longint'(udiv(64'(p + den - 1), 64'(den)));
    end else if (den < 0) begin
      n = -longint'(udiv(64'(p), 64'(-den)));
    end else begin
      n = 0;
    end
    mag = n + longint'(mid);
    if (mag > longint'(buckets)) begin
      mag = longint'(buckets);
    end
    if (mag < -longint'(buckets)) begin
      mag = -longint'(buckets);
    end
    return int'(mag);
  endfunction

endpackage

/* hw/rtl/log_bucket_relative_position_index.sv */
// An accepted transfer is registered in stage one (vld1), then in the result registers that raise done.
// Throughput: one index pair per cycle; busy is always low.
// The first stage reads the log bucket ROM, the second forms the addresses.
// Reset (synchronous) empties the pipeline and sets log_bucket_enable to 1.
// The receiver cannot stall: each result stands for exactly one cycle.
module log_bucket_relative_position_index #(
  parameter int BUCKETS = lbrp_pkg::BUCKETS_DEF,
  parameter int MAX_REL = lbrp_pkg::MAX_REL_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cfg_write,
  input  logic                       cfg_data,
  input  logic [lbrp_pkg::POS_W-1:0] query_pos,
  input  logic [lbrp_pkg::POS_W-1:0] key_pos,
  output logic                       done,
  output logic [lbrp_pkg::OUT_W-1:0] c2p_index,
  output logic [lbrp_pkg::OUT_W-1:0] p2c_index
);
  import lbrp_pkg::*;

  localparam int MID       = BUCKETS / 2;
  localparam int ROM_DEPTH = (MAX_DIST > MID) ? (MAX_DIST - MID) : 1;
  localparam int IDX_W     = (ROM_DEPTH > 1) ? $clog2(ROM_DEPTH) : 1;
  localparam int MAG_W     = $clog2(BUCKETS + 1) + 1;
  localparam int MID_W     = $clog2(MID + 2) + 1;
  localparam int CMP_W     = (MID_W > POS_W + 1) ? MID_W : POS_W + 1;

  logic                    log_bucket_enable;
  logic signed [POS_W:0]   dist_in;
  logic [POS_W-1:0]        amag_in;
  logic                    near_in;
  logic [IDX_W-1:0]        rom_addr;

  logic                    vld1;
  logic [POS_W-1:0]        q1;
  logic [POS_W-1:0]        k1;
  logic signed [POS_W:0]   dist1;
  logic                    near1;
  logic                    bucket_en1;
  logic signed [MAG_W-1:0] mag1;

  assign busy = 1'b0;

  always_comb begin
    dist_in = $signed({1'b0, query_pos}) - $signed({1'b0, key_pos});
    amag_in = dist_in[POS_W] ? POS_W'(-dist_in) : dist_in[POS_W-1:0];
    near_in = CMP_W'(amag_in) <= CMP_W'(MID);
    // Distances at or below the midpoint bypass the ROM; park the address.
    if (near_in) begin
      rom_addr = '0;
    end else begin
      rom_addr = IDX_W'(CMP_W'(amag_in) - CMP_W'(MID + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      log_bucket_enable <= 1'b1;
      vld1              <= 1'b0;
    end else begin
      if (cfg_write) begin
        log_bucket_enable <= cfg_data;
      end
      vld1 <= start && !busy;
    end
  end

  // Each transfer carries the mode that was set when it was accepted.
  always_ff @(posedge clk) begin
    q1         <= query_pos;
    k1         <= key_pos;
    dist1      <= dist_in;
    near1      <= near_in;
    bucket_en1 <= log_bucket_enable;
  end

  lbrp_rom #(
    .BUCKETS (BUCKETS),
    .MAX_REL (MAX_REL)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .mag  (mag1)
  );

  lbrp_addr #(
    .BUCKETS (BUCKETS),
    .MAX_REL (MAX_REL)
  ) u_addr (
    .clk       (clk),
    .rst       (rst),
    .vld       (vld1),
    .bucket_en (bucket_en1),
    .query_pos (q1),
    .key_pos   (k1),
    .rel_dist  (dist1),
    .near      (near1),
    .mag       (mag1),
    .done      (done),
    .c2p_index (c2p_index),
    .p2c_index (p2c_index)
  );

`ifndef NO_ASSERTIONS
  a_accept_gives_done : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted transfer produced no result strobe");

  a_done_has_source : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result strobe without an accepted transfer");

  a_stage_follows_accept : assert property (@(posedge clk) disable iff (rst)
    vld1 |-> ($past(start) && !$past(busy)))
    else $error("pipeline stage valid without an accepted transfer");
`endif

endmodule

/* hw/rtl/lbrp_rom.sv */
// Constant log bucket ROM with a registered read port.
// Entries are computed at elaboration from lbrp_pkg::bucket_mag.
module lbrp_rom #(
  parameter int BUCKETS = lbrp_pkg::BUCKETS_DEF,
  parameter int MAX_REL = lbrp_pkg::MAX_REL_DEF,
  localparam int MID       = BUCKETS / 2,
  localparam int ROM_DEPTH = (lbrp_pkg::MAX_DIST > MID) ? (lbrp_pkg::MAX_DIST - MID) : 1,
  localparam int IDX_W     = (ROM_DEPTH > 1) ? $clog2(ROM_DEPTH) : 1,
  localparam int MAG_W     = $clog2(BUCKETS + 1) + 1
) (
  input  logic                    clk,
  input  logic [IDX_W-1:0]        addr,
  output logic signed [MAG_W-1:0] mag
);
  import lbrp_pkg::*;

  logic signed [MAG_W-1:0] rom_data [ROM_DEPTH];

  // Entry i holds the bucket for distance magnitude MID + 1 + i.
  for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_entry
    localparam int ENTRY = bucket_mag(i + MID + 1, BUCKETS, MAX_REL);
    assign rom_data[i] = MAG_W'(ENTRY);
  end

  always_ff @(posedge clk) begin
    mag <= rom_data[addr];
  end

endmodule

/* hw/rtl/lbrp_addr.sv */
// Output stage: selects the bucket, offsets and clamps it, and forms both
// gather addresses into the result registers. Depends on lbrp_pkg.
module lbrp_addr #(
  parameter int BUCKETS = lbrp_pkg::BUCKETS_DEF,
  parameter int MAX_REL = lbrp_pkg::MAX_REL_DEF,
  localparam int MAG_W = $clog2(BUCKETS + 1) + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          vld,
  input  logic                          bucket_en,
  input  logic [lbrp_pkg::POS_W-1:0]    query_pos,
  input  logic [lbrp_pkg::POS_W-1:0]    key_pos,
  input  logic signed [lbrp_pkg::POS_W:0] rel_dist,
  input  logic                          near,
  input  logic signed [MAG_W-1:0]       mag,
  output logic                          done,
  output logic [lbrp_pkg::OUT_W-1:0]    c2p_index,
  output logic [lbrp_pkg::OUT_W-1:0]    p2c_index
);
  import lbrp_pkg::*;

  localparam int MAX_SPAN = (BUCKETS > MAX_REL) ? BUCKETS : MAX_REL;
  localparam int MAX_B    = (BUCKETS > (2 ** POS_W)) ? BUCKETS : (2 ** POS_W);
  localparam int V_W      = $clog2(MAX_SPAN + MAX_B + 1) + 1;
  localparam int CL_W     = $clog2(2 * MAX_SPAN);

  logic signed [V_W-1:0] b;
  logic signed [V_W-1:0] span;
  logic signed [V_W-1:0] v;
  logic signed [V_W-1:0] v_hi;
  logic [CL_W-1:0]       v_clamp;
  logic [OUT_W-1:0]      rows_sel;
  logic [OUT_W-1:0]      c2p_next;
  logic [OUT_W-1:0]      p2c_next;

  always_comb begin
    if (bucket_en && !near) begin
      b = rel_dist[POS_W] ? -V_W'(mag) : V_W'(mag);
    end else begin
      b = V_W'(rel_dist);
    end
    span = bucket_en ? V_W'(BUCKETS) : V_W'(MAX_REL);
    v    = b + span;
    v_hi = (span <<< 1) - V_W'(1);
    priority if (v > v_hi) begin
      v_clamp = CL_W'(v_hi);
    end else if (v < 0) begin
      v_clamp = '0;
    end else begin
      v_clamp = CL_W'(v);
    end
    rows_sel = bucket_en ? OUT_W'(2 * BUCKETS) : OUT_W'(2 * MAX_REL);
    // Products wrap to the address width, as the flat address does.
    c2p_next = OUT_W'(v_clamp) + OUT_W'(OUT_W'(query_pos) * rows_sel);
    p2c_next = OUT_W'(v_clamp) + OUT_W'(OUT_W'(key_pos) * rows_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld;
    end
  end

  always_ff @(posedge clk) begin
    c2p_index <= c2p_next;
    p2c_index <= p2c_next;
  end

`ifndef NO_ASSERTIONS
  // Both addresses share the clamped bucket, so they differ by rows * (q - k).
  a_addr_delta : assert property (@(posedge clk) disable iff (rst)
    vld |=> (c2p_index - p2c_index) == OUT_W'($past($signed({1'b0, rows_sel}) * rel_dist)))
    else $error("c2p and p2c addresses do not differ by rows times distance");
`endif

endmodule

/* bench/lbrp_checker.sv */
// Checker for the relative position gather address block: watches the
// command, configuration and result ports, predicts both addresses and compares.
// Depends on lbrp_pkg for the port widths.
`timescale 1ns / 100ps

module lbrp_checker #(
  parameter int BUCKETS = lbrp_pkg::BUCKETS_DEF,
  parameter int MAX_REL = lbrp_pkg::MAX_REL_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       cfg_write,
  input  logic                       cfg_data,
  input  logic [lbrp_pkg::POS_W-1:0] query_pos,
  input  logic [lbrp_pkg::POS_W-1:0] key_pos,
  input  logic                       done,
  input  logic [lbrp_pkg::OUT_W-1:0] c2p_index,
  input  logic [lbrp_pkg::OUT_W-1:0] p2c_index,
  output int                         pending,
  output int                         mismatches
);

  typedef struct packed {
    logic [lbrp_pkg::OUT_W-1:0] c2p;
    logic [lbrp_pkg::OUT_W-1:0] p2c;
  } addr_pair_t;

  addr_pair_t pending_addrs[$];
  logic       log_mode;
  int         err_cnt;

  initial begin
    pending    = 0;
    mismatches = 0;
    err_cnt    = 0;
    log_mode   = 1'b1;
  end

  // Base-2 log with 32 truncated fraction bits, by repeated squaring.
  function automatic longint lg2_q32(input int unsigned v);
    int unsigned t;
    int unsigned ex;
    bit [63:0]   m;
    bit [63:0]   fr;
    t  = v;
    ex = 0;
    fr = '0;
    if (v == 0) return 0;
    while (t > 1) begin
      t  = t >> 1;
      ex = ex + 1;
    end
    m = 64'(v) << (31 - ex);
    repeat (32) begin
      m  = (m * m) >> 31;
      fr = fr << 1;
      if (m >= 64'h1_0000_0000) begin
        fr[0] = 1'b1;
        m     = m >> 1;
      end
    end
    return longint'((64'(ex) << 32) | fr);
  endfunction

  // Signed log bucket of a distance; small distances pass through.
  function automatic int log_bucket_of(input int delta);
    int     half;
    int     mag_in;
    int     far_rel;
    longint l_half;
    longint num;
    longint den;
    longint prod;
    longint n;
    half    = BUCKETS / 2;
    mag_in  = (delta < 0) ? -delta : delta;
    far_rel = (MAX_REL > 1) ? (MAX_REL - 1) : 1;
    if (mag_in <= half) return delta;
    l_half = lg2_q32(half);
    num    = lg2_q32(mag_in) - l_half;
    den    = lg2_q32(far_rel) - l_half;
    prod   = longint'(half - 1) * num;
    // Ceiling for a positive denominator; a negative one takes the negated floor.
    if (den > 0) n = (prod + den - 1) / den;
    else if (den < 0) n = -(prod / -den);
    else n = 0;
    n = n + half;
    return (delta < 0) ? -int'(n) : int'(n);
  endfunction

  function automatic addr_pair_t gather_addrs(input logic use_log,
                                              input logic [lbrp_pkg::POS_W-1:0] q,
                                              input logic [lbrp_pkg::POS_W-1:0] k);
    int         span;
    int         b;
    longint     v;
    longint     rows;
    addr_pair_t res;
    span = use_log ? BUCKETS : MAX_REL;
    b    = int'(q) - int'(k);
    if (use_log) b = log_bucket_of(b);
    v = longint'(b) + span;
    if (v > 2 * longint'(span) - 1) v = 2 * longint'(span) - 1;
    if (v < 0) v = 0;
    rows    = 2 * longint'(span);
    res.c2p = lbrp_pkg::OUT_W'(v + rows * longint'(q));
    res.p2c = lbrp_pkg::OUT_W'(v + rows * longint'(k));
    return res;
  endfunction

  always @(posedge clk) begin
    addr_pair_t want;
    if (!rst) begin
      if (done) begin
        if (pending_addrs.size() == 0) begin
          $display("%0t: result c2p_index=%0d p2c_index=%0d with none expected",
                   $time, c2p_index, p2c_index);
          err_cnt++;
        end else begin
          want = pending_addrs.pop_front();
          if (c2p_index !== want.c2p) begin
            $display("%0t: c2p_index expected %0d, actual %0d", $time, want.c2p, c2p_index);
            err_cnt++;
          end
          if (p2c_index !== want.p2c) begin
            $display("%0t: p2c_index expected %0d, actual %0d", $time, want.p2c, p2c_index);
            err_cnt++;
          end
        end
      end
      // A transfer at the same edge as a register write still sees the old setting.
      if (start && !busy) pending_addrs.push_back(gather_addrs(log_mode, query_pos, key_pos));
      if (cfg_write) log_mode = cfg_data;
    end else begin
      log_mode = 1'b1;
    end
    pending    <= pending_addrs.size();
    mismatches <= err_cnt;
  end

endmodule

/* bench/tb_top.sv */
// Top of the testbench for log_bucket_relative_position_index: drives index
// pairs and register writes, and gives the verdict from lbrp_checker.
// Depends on lbrp_pkg, the block and bench/lbrp_checker.sv.
`timescale 1ns / 100ps

module tb_top;

  localparam int HALF        = lbrp_pkg::BUCKETS_DEF / 2;
  localparam int POS_MAX     = lbrp_pkg::MAX_DIST;
  localparam int STALL_LIMIT = 2000;
  localparam int N_DIRECTED  = 12;

  typedef enum {IDLE_NONE, IDLE_HEAVY, IDLE_LIGHT} idle_mode_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       start     = 1'b0;
  logic                       cfg_write = 1'b0;
  logic                       cfg_data  = 1'b0;
  logic [lbrp_pkg::POS_W-1:0] query_pos = '0;
  logic [lbrp_pkg::POS_W-1:0] key_pos   = '0;
  logic                       busy;
  logic                       done;
  logic [lbrp_pkg::OUT_W-1:0] c2p_index;
  logic [lbrp_pkg::OUT_W-1:0] p2c_index;
  int                         pending;
  int                         mismatches;
  int                         stall_cycles;

  // Distance edges: zero, both signs at and past half the bucket count,
  // the farthest distance in each direction.
  int unsigned dir_q[N_DIRECTED] = '{0, 511, 511, 0, 128, 0, 129, 0, 511, 255, 0, 341};
  int unsigned dir_k[N_DIRECTED] = '{0, 511, 0, 511, 0, 128, 0, 129, 510, 0, 256, 170};

  log_bucket_relative_position_index u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .query_pos (query_pos),
    .key_pos   (key_pos),
    .done      (done),
    .c2p_index (c2p_index),
    .p2c_index (p2c_index)
  );

  lbrp_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .query_pos  (query_pos),
    .key_pos    (key_pos),
    .done       (done),
    .c2p_index  (c2p_index),
    .p2c_index  (p2c_index),
    .pending    (pending),
    .mismatches (mismatches)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Ends the run when neither side completes a transfer for too long.
  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if ((start && !busy) || done || rst) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_pair(input int unsigned q, input int unsigned k);
    start     <= 1'b1;
    query_pos <= lbrp_pkg::POS_W'(q);
    key_pos   <= lbrp_pkg::POS_W'(k);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(input idle_mode_t mode);
    int gap;
    gap = 0;
    case (mode)
      IDLE_HEAVY: gap = $urandom_range(1, 12);
      IDLE_LIGHT: if ($urandom_range(0, 99) < 30) gap = $urandom_range(1, 2);
      default:    gap = 0;
    endcase
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every address pair has come back.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_log_mode(input logic en);
    drain();
    cfg_write <= 1'b1;
    cfg_data  <= en;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_directed;
    for (int i = 0; i < N_DIRECTED; i++) send_pair(dir_q[i], dir_k[i]);
  endtask

  // Half of the pairs are drawn uniformly, the rest with distances near the bucket edge or near zero.
  task automatic run_random(input int count, input idle_mode_t mode);
    int q;
    int k;
    int d;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, POS_MAX);
      q = $urandom_range(0, POS_MAX);
      case ($urandom_range(0, 3))
        2: d = $urandom_range(HALF - 8, HALF + 8);
        3: d = $urandom_range(0, 4);
        default: d = -1;
      endcase
      if (d >= 0) begin
        q = ($urandom_range(0, 1) == 1) ? k + d : k - d;
        if (q > POS_MAX) q = k - d;
        if (q < 0) q = k + d;
        if (q < 0 || q > POS_MAX) q = $urandom_range(0, POS_MAX);
      end
      send_pair(q, k);
      hold_off(mode);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    set_log_mode(1'b0);
    run_directed();

    set_log_mode(1'b1);
    run_random(500, IDLE_NONE);
    run_random(400, IDLE_HEAVY);
    set_log_mode(1'b0);
    run_random(400, IDLE_LIGHT);
    run_random(300, IDLE_HEAVY);
    set_log_mode(1'b1);
    run_random(300, IDLE_LIGHT);

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/lbrp_pkg.sv
hw/rtl/lbrp_rom.sv
hw/rtl/lbrp_addr.sv
hw/rtl/log_bucket_relative_position_index.sv
bench/lbrp_checker.sv
bench/tb_top.sv
